### hw/rtl/itrt_pkg.sv
`default_nettype none
package itrt_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 64;
  localparam int unsigned RAW_WIDTH       = 64;
  localparam int unsigned RADIX_WIDTH     = 6;
  localparam int unsigned CHAR_WIDTH      = 8;

  localparam logic [CHAR_WIDTH-1:0]  CH_ZERO    = 8'h30;
  localparam logic [CHAR_WIDTH-1:0]  CH_LOWER_A = 8'h61;
  localparam logic [CHAR_WIDTH-1:0]  CH_MINUS   = 8'h2D;
  localparam logic [RADIX_WIDTH-1:0] DECIMAL    = 6'd10;
  localparam logic [RADIX_WIDTH-1:0] RADIX_MIN  = 6'd2;
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX  = 6'd36;

  // Status of the divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [RADIX_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] ch;
    if (d < DECIMAL) begin
      ch = CH_ZERO + {2'b00, d};
    end else begin
      ch = CH_LOWER_A + {2'b00, d - DECIMAL};
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/itrt_ram.sv
`default_nettype none
module itrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/itrt_divider.sv
`default_nettype none
module itrt_divider
  import itrt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [VALUE_WIDTH-1:0] dividend_i,
  input  wire logic [RADIX_WIDTH-1:0] divisor_i,
  output div_stat_t                   stat_o,
  output logic      [VALUE_WIDTH-1:0] quotient_o,
  output logic      [RADIX_WIDTH-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] quo_q;
  logic [RADIX_WIDTH-1:0] rem_q;
  logic [RADIX_WIDTH-1:0] div_q;
  logic [CntW-1:0]        cnt_q;
  logic                   busy_q;
  logic                   done_q;

  logic [RADIX_WIDTH:0] rem_sh;
  logic [RADIX_WIDTH:0] rem_sub;
  logic                 fits;

  // One restoring step: bring down the next dividend bit and try the divisor.
  always_comb begin
    rem_sh  = {rem_q, quo_q[VALUE_WIDTH-1]};
    fits    = rem_sh >= {1'b0, div_q};
    rem_sub = rem_sh - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(VALUE_WIDTH - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
      rem_q <= fits ? rem_sub[RADIX_WIDTH-1:0] : rem_sh[RADIX_WIDTH-1:0];
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule
`default_nettype wire

### hw/rtl/integer_to_radix_text_core.sv
// Converts one integer to ASCII text, most significant character first.
// Each digit is found in turn by the bit-serial divider and pushed onto a digit stack;
// the characters are then read back from the stack through the READ, LOAD and OUT states.
// The block takes one number at a time and is ready for the next only once the last
// character of the current number has been taken.
// Reset is asynchronous and active low; it returns the sequencer to idle.
`default_nettype none
module integer_to_radix_text_core
  import itrt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [RAW_WIDTH-1:0]   raw_value_i,
  input  wire logic                   is_signed_i,
  input  wire logic [RADIX_WIDTH-1:0] radix_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [CHAR_WIDTH-1:0]  character_o,
  output logic                        last_o
);

  localparam int unsigned AddrW = $clog2(VALUE_WIDTH);
  localparam int unsigned CntW  = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_LOAD,
    ST_OUT
  } state_e;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   sign_q, sign_d;
  logic                   valid_q, valid_d;
  logic [CHAR_WIDTH-1:0]  char_q, char_d;
  logic                   last_q, last_d;
  logic [RADIX_WIDTH-1:0] radix_q, radix_d;

  logic [VALUE_WIDTH-1:0] value;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic [RADIX_WIDTH-1:0] radix_eff;
  logic                   negative;
  logic                   in_xfer;
  logic                   out_xfer;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [RADIX_WIDTH-1:0] div_divisor;
  div_stat_t              div_stat;
  logic [VALUE_WIDTH-1:0] div_quotient;
  logic [RADIX_WIDTH-1:0] div_remainder;

  logic                   ram_we;
  logic                   ram_re;
  logic [CHAR_WIDTH-1:0]  ram_rdata;
  logic [CntW-1:0]        count_dec;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign out_xfer   = valid_q & out_ready_i;
  assign count_dec  = count_q - 1'b1;

  always_comb begin
    value = raw_value_i[VALUE_WIDTH-1:0];
    if (radix_i < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_i > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_i;
    end
    negative  = is_signed_i && (radix_eff == DECIMAL) && value[VALUE_WIDTH-1];
    magnitude = negative ? (~value + 1'b1) : value;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    sign_d       = sign_q;
    valid_d      = valid_q;
    char_d       = char_q;
    last_d       = last_q;
    radix_d      = radix_q;
    div_start    = 1'b0;
    div_dividend = div_quotient;
    div_divisor  = radix_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          div_start    = 1'b1;
          div_dividend = magnitude;
          div_divisor  = radix_eff;
          radix_d      = radix_eff;
          sign_d       = negative;
          count_d      = '0;
          state_d      = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          ram_we  = 1'b1;
          count_d = count_q + 1'b1;
          if (div_quotient != '0) begin
            div_start = 1'b1;
          end else if (sign_q) begin
            char_d  = CH_MINUS;
            last_d  = 1'b0;
            valid_d = 1'b1;
            state_d = ST_SIGN;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_SIGN: begin
        if (out_xfer) begin
          valid_d = 1'b0;
          sign_d  = 1'b0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        char_d  = ram_rdata;
        last_d  = (count_q == CntW'(1));
        valid_d = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_xfer) begin
          valid_d = 1'b0;
          count_d = count_dec;
          state_d = last_q ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      sign_q  <= 1'b0;
      valid_q <= 1'b0;
      char_q  <= '0;
      last_q  <= 1'b0;
      radix_q <= RADIX_MIN;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sign_q  <= sign_d;
      valid_q <= valid_d;
      char_q  <= char_d;
      last_q  <= last_d;
      radix_q <= radix_d;
    end
  end

  itrt_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .stat_o      (div_stat),
    .quotient_o  (div_quotient),
    .remainder_o (div_remainder)
  );

  // Digits are stacked least significant first and read back in reverse.
  itrt_ram #(
    .WIDTH(CHAR_WIDTH),
    .DEPTH(VALUE_WIDTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (digit_char(div_remainder)),
    .re_i    (ram_re),
    .raddr_i (count_dec[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

### verif/integer_to_radix_text_core_tb.sv
`timescale 1ns / 1ps
module integer_to_radix_text_core_tb;
  import itrt_pkg::*;

  localparam int unsigned VW           = VALUE_WIDTH_DEF;
  localparam int unsigned HOLD_CYCLES  = 4000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RUN_LIMIT_NS = 20_000_000;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] character;
    logic                  last;
  } text_char_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic [RAW_WIDTH-1:0]   raw_value_i = '0;
  logic                   is_signed_i = 1'b0;
  logic [RADIX_WIDTH-1:0] radix_i     = DECIMAL;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [CHAR_WIDTH-1:0]  character_o;
  logic                   last_o;

  text_char_t  expected_text[$];
  int unsigned mismatch_count = 0;
  logic        idling_on      = 1'b0;
  logic        hold_off       = 1'b0;
  event        hold_go;

  integer_to_radix_text_core #(
    .VALUE_WIDTH(VW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .raw_value_i(raw_value_i),
    .is_signed_i(is_signed_i),
    .radix_i    (radix_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Works out the characters of one number, most significant first, and queues them.
  function automatic void predict_text(input logic [RAW_WIDTH-1:0] raw,
                                       input logic as_signed,
                                       input logic [RADIX_WIDTH-1:0] radix_in);
    logic [63:0]           mask;
    logic [63:0]           magnitude;
    logic [63:0]           base;
    logic [63:0]           digit;
    logic                  minus;
    logic [CHAR_WIDTH-1:0] digits[64];
    int                    count;
    text_char_t            entry;
    mask      = {64{1'b1}} >> (64 - VW);
    magnitude = raw & mask;
    if (radix_in < RADIX_MIN) begin
      base = 64'(RADIX_MIN);
    end else if (radix_in > RADIX_MAX) begin
      base = 64'(RADIX_MAX);
    end else begin
      base = 64'(radix_in);
    end
    // Only decimal gets a sign; other radices show the two's complement bits.
    minus = as_signed && (base == 64'(DECIMAL)) && magnitude[VW-1];
    if (minus) begin
      magnitude = (~magnitude + 64'd1) & mask;
    end
    count = 0;
    do begin
      digit = magnitude % base;
      if (digit < 64'(DECIMAL)) begin
        digits[count] = CH_ZERO + digit[CHAR_WIDTH-1:0];
      end else begin
        digits[count] = CH_LOWER_A + digit[CHAR_WIDTH-1:0] - {2'b00, DECIMAL};
      end
      count++;
      magnitude = magnitude / base;
    end while (magnitude != 0);
    if (minus) begin
      entry.character = CH_MINUS;
      entry.last      = 1'b0;
      expected_text.push_back(entry);
    end
    for (int i = count - 1; i >= 0; i--) begin
      entry.character = digits[i];
      entry.last      = (i == 0);
      expected_text.push_back(entry);
    end
  endfunction

  // Offers one number and returns at the edge of its transfer, leaving valid high so
  // that a following number can be offered without a gap.
  task automatic send_number(input logic [RAW_WIDTH-1:0] value, input logic as_signed,
                             input logic [RADIX_WIDTH-1:0] radix);
    int unsigned gap;
    gap = idling_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    raw_value_i <= value;
    is_signed_i <= as_signed;
    radix_i     <= radix;
    do @(posedge clk_i); while (!in_ready_o);
    predict_text(value, as_signed, radix);
  endtask

  initial begin : hold_counter
    forever begin
      @(hold_go);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_off <= 1'b0;
    end
  end

  initial begin : drive_ready
    int unsigned ready_wait;
    forever begin
      ready_wait = idling_on ? $urandom_range(0, 7) : 0;
      if (ready_wait != 0 || hold_off) begin
        out_ready_i <= 1'b0;
        repeat (ready_wait) @(posedge clk_i);
        while (hold_off) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i) && !hold_off);
    end
  end

  always @(posedge clk_i) begin : check_text
    text_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_text.size() == 0) begin
        $error("character: expected none, got %h", character_o);
        mismatch_count++;
      end else begin
        want = expected_text.pop_front();
        if (character_o !== want.character) begin
          $error("character: expected %h, got %h", want.character, character_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %b, got %b", want.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_zero_and_small();
    send_number('0, 1'b0, DECIMAL);
    send_number('0, 1'b1, RADIX_MIN);
    send_number(64'd1, 1'b0, RADIX_MIN);
    send_number(64'd35, 1'b0, RADIX_MAX);
    send_number(64'd10, 1'b0, 6'd16);
  endtask

  task automatic test_width_extremes();
    send_number('1, 1'b0, RADIX_MIN);
    send_number('1, 1'b0, RADIX_MAX);
    send_number('1, 1'b0, DECIMAL);
    send_number('1, 1'b1, DECIMAL);
    // The most negative value has no positive counterpart in the same width.
    send_number(64'h8000_0000_0000_0000, 1'b1, DECIMAL);
    send_number(64'h8000_0000_0000_0000, 1'b0, DECIMAL);
    send_number(64'h7fff_ffff_ffff_ffff, 1'b1, DECIMAL);
    send_number(64'h8000_0000_0000_0000, 1'b1, 6'd16);
  endtask

  task automatic test_radix_clamp();
    send_number(64'd12345, 1'b0, 6'd0);
    send_number(64'd12345, 1'b0, 6'd1);
    send_number(64'd12345, 1'b0, 6'd37);
    send_number(64'd123456789, 1'b0, 6'd63);
    send_number('1, 1'b1, 6'd0);
  endtask

  // The receiver stops for a long while, so the block stalls with numbers still offered.
  task automatic test_output_backpressure();
    idling_on = 1'b0;
    -> hold_go;
    for (int k = 0; k < 5; k++) begin
      send_number({$urandom, $urandom}, 1'b1, DECIMAL);
    end
  endtask

  task automatic test_random_numbers(input int unsigned count);
    logic [RAW_WIDTH-1:0]   value;
    logic [RADIX_WIDTH-1:0] radix;
    for (int unsigned k = 0; k < count; k++) begin
      // Every third stretch of forty numbers runs without idling on either side.
      idling_on = ((k / 40) % 3) != 2;
      case ($urandom_range(0, 4))
        0:       value = {$urandom, $urandom};
        1:       value = RAW_WIDTH'($urandom_range(0, 999));
        2:       value = {32'h0, $urandom};
        3:       value = ~RAW_WIDTH'($urandom_range(0, 999));
        default: value = {1'b1, 31'h0, $urandom};
      endcase
      radix = ($urandom_range(0, 3) == 0) ? DECIMAL : RADIX_WIDTH'($urandom_range(0, 63));
      send_number(value, 1'($urandom_range(0, 1)), radix);
    end
  endtask

  initial begin : run_tests
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_zero_and_small();
    test_width_extremes();
    test_radix_clamp();
    test_output_backpressure();
    test_random_numbers(160);
    in_valid_i <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("integer_to_radix_text_core_tb passed");
    end else begin
      $display("integer_to_radix_text_core_tb failed");
    end
    $finish;
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("integer_to_radix_text_core_tb failed");
    $finish;
  end

endmodule

### files.f
hw/rtl/itrt_pkg.sv
hw/rtl/itrt_ram.sv
hw/rtl/itrt_divider.sv
hw/rtl/integer_to_radix_text_core.sv
verif/integer_to_radix_text_core_tb.sv
